### rtl/svpwm_pkg.sv
// svpwm_pkg: shared types and constants for the servo pulse generator
// item, result, command, configuration write and divider request/response
// structs, request and register codes; no dependencies
package svpwm_pkg;

    // frame length in microseconds
    localparam logic [15:0] FRAME_US = 16'd20000;

    // division by the frame length: drop 5 bits (20000 = 32 * 625), then
    // multiply by ceil(2^36 / 625) and keep the bits from 36 up; exact for
    // dividends below 2^31
    localparam int          FRAME_PRE_SH   = 5;
    localparam int          FRAME_RECIP_SH = 36;
    localparam logic [26:0] FRAME_RECIP    = 27'd109951163;

    // operand width of the shared multiplier and divider
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_ANGLE = 2'd1;
    localparam logic [1:0] REQ_US    = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd6;

    // one input request
    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] angle_in;
        logic [15:0]        pulse_in_us;
    } t_item;

    // one result
    typedef struct packed {
        logic               pwm_level;
        logic [15:0]        compare_now;
        logic [15:0]        read_us;
        logic signed [15:0] read_angle;
        logic               frame_start;
    } t_result;

    // classified request as held in the front queue
    typedef struct packed {
        logic               tick;
        logic               write_angle;
        logic               write_us;
        logic               read_back;
        logic signed [15:0] angle;
        logic [15:0]        pulse;
    } t_cmd;

    // configuration write
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic signed [MUL_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/servo_pwm_angle_generator.sv
// Servo pulse generator with a 20 ms frame. Requests enter through a command
// queue and become visible to the back end in the cycle after they are pushed;
// a tick request needs neither multiplier nor divider, so ticks run at one per
// clock as long as results are popped and no other request is executing. A
// pulse-width write takes one multiply, then a division by the frame length
// through a fixed reciprocal. An angle write first maps the angle through the
// shared multiplier and the bit-serial divider (34 quotient bits, one a cycle)
// and then scales the width (the mapping is skipped with equal angle ends); a
// read-back makes two passes through the multiplier and divider (one with equal
// pulse ends or when detached or the period is zero, none with both). Detached
// writes only push a result. Requests are executed one at a time, in order, and
// the front queue keeps accepting while the back end is busy. Configuration
// writes are taken at any time but must only be issued while no request is
// outstanding; enabling clears the counters and both compare values.
// Top level; depends on svpwm_pkg, svpwm_front, svpwm_div, svpwm_back
module servo_pwm_angle_generator #(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  svpwm_pkg::t_item                      i_item,
    output logic                                  empty,
    input  logic                                  pop,
    output svpwm_pkg::t_result                    o_result,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                cmd_valid;
    logic                cmd_take;
    svpwm_pkg::t_cmd     cmd;
    svpwm_pkg::t_div_req div_req;
    svpwm_pkg::t_div_rsp div_rsp;
    svpwm_pkg::t_cfg_wr  cfg_wr;

    // registers are always writable
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // request intake
    svpwm_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // shared divider
    svpwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // execution and result queue
    svpwm_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

### rtl/svpwm_front.sv
// svpwm_front: request intake, classification and command queue
// depends on svpwm_pkg
module svpwm_front #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  svpwm_pkg::t_item  i_item,
    output logic              o_cmd_valid,
    output svpwm_pkg::t_cmd   o_cmd,
    input  logic              i_cmd_take
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);

    svpwm_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    svpwm_pkg::t_cmd cls;
    logic            wr_en;
    logic            rd_en;

    assign o_full      = (r_cnt == CW'(DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    // decode the request type into one class flag
    always_comb begin
        cls       = '0;
        cls.angle = i_item.angle_in;
        cls.pulse = i_item.pulse_in_us;
        case (i_item.req_type)
            svpwm_pkg::REQ_TICK:  cls.tick        = 1'b1;
            svpwm_pkg::REQ_ANGLE: cls.write_angle = 1'b1;
            svpwm_pkg::REQ_US:    cls.write_us    = 1'b1;
            default:              cls.read_back   = 1'b1;
        endcase
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### rtl/svpwm_div.sv
// svpwm_div: signed divider, truncating towards zero, one quotient bit a cycle
// depends on svpwm_pkg
module svpwm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svpwm_pkg::t_div_req i_req,
    output svpwm_pkg::t_div_rsp o_rsp
);

    localparam int PW    = svpwm_pkg::PROD_W;
    localparam int MW    = svpwm_pkg::MUL_W;
    localparam int STEPS = PW;
    localparam int SW    = $clog2(STEPS);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [PW-1:0] r_quo;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_den;
    logic          r_neg;
    logic [PW-1:0] num_mag;
    logic [MW-1:0] den_mag;
    logic [MW:0]   rem_sh;
    logic [MW:0]   rem_sub;
    logic          ge;

    // operand magnitudes
    assign num_mag = i_req.dividend[PW-1] ? (~i_req.dividend + PW'(1)) : i_req.dividend;
    assign den_mag = i_req.divisor[MW-1]  ? (~i_req.divisor + MW'(1))  : i_req.divisor;

    // one restoring step
    assign rem_sh  = {r_rem, r_quo[PW-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~r_quo + PW'(1)) : r_quo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= num_mag;
            r_den <= den_mag;
            r_rem <= '0;
            r_neg <= i_req.dividend[PW-1] ^ i_req.divisor[MW-1];
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
            r_quo <= {r_quo[PW-2:0], ge};
        end
    end

endmodule

### rtl/svpwm_back.sv
// svpwm_back: executes requests: prescaler, frame counter, compare preload,
// angle and width mapping through the shared multiplier and divider; result queue
// depends on svpwm_pkg
module svpwm_back #(
    parameter int OUT_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svpwm_pkg::t_cfg_wr  i_cfg,
    input  logic                i_cmd_valid,
    input  svpwm_pkg::t_cmd     i_cmd,
    output logic                o_cmd_take,
    output svpwm_pkg::t_div_req o_div_req,
    input  svpwm_pkg::t_div_rsp i_div_rsp,
    input  logic                i_pop,
    output logic                o_empty,
    output svpwm_pkg::t_result  o_result
);

    localparam int MW = svpwm_pkg::MUL_W;
    localparam int PW = svpwm_pkg::PROD_W;
    localparam int AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH + 1);

    // sequencer states and operation phases
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    localparam logic [1:0] PH_ANG  = 2'd0;
    localparam logic [1:0] PH_US   = 2'd1;
    localparam logic [1:0] PH_RUS  = 2'd2;
    localparam logic [1:0] PH_RANG = 2'd3;

    // configuration registers
    logic               r_enable;
    logic [14:0]        r_min_pulse;
    logic [14:0]        r_max_pulse;
    logic signed [15:0] r_min_angle;
    logic signed [15:0] r_max_angle;
    logic [16:0]        r_prescale;
    logic [15:0]        r_period;

    // timer state
    logic [15:0] r_pc, n_pc;
    logic [15:0] r_fc, n_fc;
    logic [15:0] r_cp, n_cp;
    logic [15:0] r_ca, n_ca;

    // sequencer and arithmetic registers
    logic [1:0]           r_state, n_state;
    logic [1:0]           r_phase, n_phase;
    logic signed [MW-1:0] r_mul_a, n_mul_a;
    logic signed [MW-1:0] r_mul_b, n_mul_b;
    logic signed [MW-1:0] r_den, n_den;
    logic signed [PW-1:0] r_prod;
    logic [15:0]          r_rd_us, n_rd_us;

    // result queue
    svpwm_pkg::t_result r_oq [OUT_DEPTH];
    logic [AW-1:0]      r_oq_wr;
    logic [AW-1:0]      r_oq_rd;
    logic [CW-1:0]      r_oq_cnt;

    logic               take;
    logic               oq_room;
    logic               oq_pop;
    logic               cfg_attach;
    logic [16:0]        div_eff;
    logic [16:0]        pc_inc;
    logic               hit;
    logic signed [15:0] a_cl;
    logic signed [MW-1:0] a_off;
    logic signed [MW-1:0] a_span;
    logic signed [MW-1:0] p_span;
    logic [15:0]        q16;
    logic [52:0]        us_recip;
    logic [15:0]        cmp_q;
    logic               us_go;
    logic [15:0]        us_src;
    logic [15:0]        w_cl;
    logic               ra_go;
    logic [15:0]        ra_src;
    logic               res_push;
    logic               res_frame;
    logic [15:0]        res_us;
    logic [15:0]        res_angle;
    svpwm_pkg::t_result res;

    // clamp a width to the pulse range, low end tested first
    function automatic logic [15:0] f_clamp_us(input logic [15:0] x,
                                               input logic [14:0] lo,
                                               input logic [14:0] hi);
        if (x < {1'b0, lo}) begin
            f_clamp_us = {1'b0, lo};
        end else if (x > {1'b0, hi}) begin
            f_clamp_us = {1'b0, hi};
        end else begin
            f_clamp_us = x;
        end
    endfunction

    // read-back angle correction away from the range ends
    function automatic logic [15:0] f_fix(input logic [15:0] a,
                                          input logic [15:0] lo,
                                          input logic [15:0] hi);
        if (a != lo && a != hi) begin
            f_fix = a + 16'd1;
        end else begin
            f_fix = a;
        end
    endfunction

    assign oq_room    = (r_oq_cnt != CW'(OUT_DEPTH));
    assign oq_pop     = i_pop && (r_oq_cnt != '0);
    assign o_empty    = (r_oq_cnt == '0);
    assign o_result   = r_oq[r_oq_rd];
    assign take       = (r_state == S_IDLE) && i_cmd_valid && oq_room;
    assign o_cmd_take = take;

    // attaching re-initialises the timer
    assign cfg_attach = i_cfg.valid && (i_cfg.index == svpwm_pkg::CFG_ENABLE)
                        && i_cfg.data[0] && !r_enable;

    // prescaler limits and step
    always_comb begin
        if (r_prescale == 17'd0) begin
            div_eff = 17'd1;
        end else if (r_prescale > 17'd65536) begin
            div_eff = 17'd65536;
        end else begin
            div_eff = r_prescale;
        end
    end
    assign pc_inc = {1'b0, r_pc} + 17'd1;
    assign hit    = (pc_inc >= div_eff);

    // angle clamp and spans
    assign a_cl   = (i_cmd.angle < r_min_angle) ? r_min_angle :
                    (i_cmd.angle > r_max_angle) ? r_max_angle : i_cmd.angle;
    assign a_off  = {a_cl[15], a_cl} - {r_min_angle[15], r_min_angle};
    assign a_span = {r_max_angle[15], r_max_angle} - {r_min_angle[15], r_min_angle};
    assign p_span = {2'b0, r_max_pulse} - {2'b0, r_min_pulse};
    assign q16    = i_div_rsp.quotient[15:0];

    // width times period over the frame length, by reciprocal multiplication
    assign us_recip = r_prod[30:svpwm_pkg::FRAME_PRE_SH] * svpwm_pkg::FRAME_RECIP;
    assign cmp_q    = us_recip[svpwm_pkg::FRAME_RECIP_SH +: 16];

    // divider request
    assign o_div_req.start    = (r_state == S_DIV) && (r_phase != PH_US);
    assign o_div_req.dividend = r_prod;
    assign o_div_req.divisor  = r_den;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        n_den     = r_den;
        n_rd_us   = r_rd_us;
        n_pc      = r_pc;
        n_fc      = r_fc;
        n_cp      = r_cp;
        n_ca      = r_ca;
        res_push  = 1'b0;
        res_frame = 1'b0;
        res_us    = '0;
        res_angle = '0;
        us_go     = 1'b0;
        us_src    = '0;
        ra_go     = 1'b0;
        ra_src    = '0;
        w_cl      = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_cmd.tick) begin
                        res_push = 1'b1;
                        if (r_enable) begin
                            if (hit) begin
                                n_pc = '0;
                                if (r_fc >= r_period) begin
                                    n_fc      = '0;
                                    n_ca      = r_cp;
                                    res_frame = 1'b1;
                                end else begin
                                    n_fc = r_fc + 16'd1;
                                end
                            end else begin
                                n_pc = pc_inc[15:0];
                            end
                        end
                    end else if (i_cmd.write_angle) begin
                        if (!r_enable) begin
                            res_push = 1'b1;
                        end else if (r_max_angle == r_min_angle) begin
                            us_go  = 1'b1;
                            us_src = {1'b0, r_min_pulse};
                        end else begin
                            n_mul_a = a_off;
                            n_mul_b = p_span;
                            n_den   = a_span;
                            n_phase = PH_ANG;
                            n_state = S_MUL;
                        end
                    end else if (i_cmd.write_us) begin
                        if (!r_enable) begin
                            res_push = 1'b1;
                        end else begin
                            us_go  = 1'b1;
                            us_src = i_cmd.pulse;
                        end
                    end else begin
                        if (r_enable && r_period != 16'd0) begin
                            n_mul_a = {1'b0, r_cp};
                            n_mul_b = {1'b0, svpwm_pkg::FRAME_US};
                            n_den   = {1'b0, r_period};
                            n_phase = PH_RUS;
                            n_state = S_MUL;
                        end else begin
                            ra_go  = 1'b1;
                            ra_src = '0;
                        end
                    end
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                // compare value comes straight from the reciprocal product
                if (r_phase == PH_US) begin
                    n_cp     = cmp_q;
                    res_push = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = S_IDLE;
                    case (r_phase)
                        PH_ANG: begin
                            us_go  = 1'b1;
                            us_src = q16 + {1'b0, r_min_pulse};
                        end
                        PH_RUS: begin
                            ra_go  = 1'b1;
                            ra_src = q16;
                        end
                        default: begin
                            res_push  = 1'b1;
                            res_us    = r_rd_us;
                            res_angle = f_fix(q16 + r_min_angle, r_min_angle, r_max_angle);
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // width to compare value
        if (us_go) begin
            w_cl    = f_clamp_us(us_src, r_min_pulse, r_max_pulse);
            n_mul_a = {1'b0, w_cl};
            n_mul_b = {1'b0, r_period};
            n_den   = {1'b0, svpwm_pkg::FRAME_US};
            n_phase = PH_US;
            n_state = S_MUL;
        end

        // read-back width to angle
        if (ra_go) begin
            n_rd_us = ra_src;
            if (r_max_pulse == r_min_pulse) begin
                res_push  = 1'b1;
                res_us    = ra_src;
                res_angle = f_fix(r_min_angle, r_min_angle, r_max_angle);
                n_state   = S_IDLE;
            end else begin
                n_mul_a = {1'b0, ra_src} - {2'b0, r_min_pulse};
                n_mul_b = a_span;
                n_den   = p_span;
                n_phase = PH_RANG;
                n_state = S_MUL;
            end
        end
    end

    // result assembly
    always_comb begin
        res.pwm_level   = r_enable && (n_fc < n_ca);
        res.compare_now = n_cp;
        res.read_us     = res_us;
        res.read_angle  = res_angle;
        res.frame_start = res_frame;
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        r_mul_a <= n_mul_a;
        r_mul_b <= n_mul_b;
        r_den   <= n_den;
        r_rd_us <= n_rd_us;
        r_prod  <= r_mul_a * r_mul_b;
        if (res_push) begin
            r_oq[r_oq_wr] <= res;
        end
    end

    // control, timer and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ANG;
            r_pc        <= '0;
            r_fc        <= '0;
            r_cp        <= '0;
            r_ca        <= '0;
            r_oq_wr     <= '0;
            r_oq_rd     <= '0;
            r_oq_cnt    <= '0;
            r_enable    <= 1'b0;
            r_min_pulse <= 15'd544;
            r_max_pulse <= 15'd2400;
            r_min_angle <= 16'sd0;
            r_max_angle <= 16'sd180;
            r_prescale  <= 17'd22;
            r_period    <= 16'd65455;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pc    <= cfg_attach ? '0 : n_pc;
            r_fc    <= cfg_attach ? '0 : n_fc;
            r_cp    <= cfg_attach ? '0 : n_cp;
            r_ca    <= cfg_attach ? '0 : n_ca;

            // result queue pointers
            if (res_push) begin
                r_oq_wr <= (r_oq_wr == AW'(OUT_DEPTH - 1)) ? '0 : r_oq_wr + AW'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= (r_oq_rd == AW'(OUT_DEPTH - 1)) ? '0 : r_oq_rd + AW'(1);
            end
            if (res_push && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + CW'(1);
            end else if (oq_pop && !res_push) begin
                r_oq_cnt <= r_oq_cnt - CW'(1);
            end

            // register writes; the user must issue them only while idle, the block does not enforce it
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    svpwm_pkg::CFG_ENABLE:       r_enable    <= i_cfg.data[0];
                    svpwm_pkg::CFG_MIN_PULSE:    r_min_pulse <= i_cfg.data[14:0];
                    svpwm_pkg::CFG_MAX_PULSE:    r_max_pulse <= i_cfg.data[14:0];
                    svpwm_pkg::CFG_MIN_ANGLE:    r_min_angle <= i_cfg.data[15:0];
                    svpwm_pkg::CFG_MAX_ANGLE:    r_max_angle <= i_cfg.data[15:0];
                    svpwm_pkg::CFG_PRESCALE:     r_prescale  <= i_cfg.data;
                    svpwm_pkg::CFG_FRAME_PERIOD: r_period    <= i_cfg.data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
